[src/poa_pkg.sv]
package poa_pkg;

  // Built size and owner width
  localparam int NUM_PAGES_DEF  = 64;
  localparam int OWNER_BITS_DEF = 4;

  // Fixed field widths
  localparam int PAGE_IDX_W = 6;
  localparam int COUNT_W    = 7;
  localparam int PID_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int PCT_W      = 7;
  localparam int TOTAL_RST  = 64;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_EVICT = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EVICT  = 2'd2;

  // Usage divider widths: (200*used + T) / (2*T)
  localparam int DIV_NUM_W  = 15;
  localparam int DIV_DEN_W  = 8;
  localparam int DIV_STEP_W = 4;
  localparam int PCT_MAX    = 100;
  localparam int PCT_SCALE  = 200;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_DECIDE,
    ST_DIVIDE,
    ST_EMIT,
    ST_REPLY
  } state_t;

  // Request to the usage divider
  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] used;
    logic [COUNT_W-1:0] total;
  } div_req_t;

  // Answer from the usage divider
  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] usage;
  } div_rsp_t;

endpackage

[src/poa_cell.sv]
module poa_cell
  import poa_pkg::*;
#(
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  logic [OWNER_BITS-1:0] owner_in,
  output logic [OWNER_BITS-1:0] owner_out
);

  logic [OWNER_BITS-1:0] owner;

  // Take the neighbor's owner on every shift
  always_ff @(posedge clk) begin
    if (rst) begin
      owner <= '0;
    end else if (shift) begin
      owner <= owner_in;
    end
  end

  assign owner_out = owner;

endmodule

[src/poa_div.sv]
module poa_div
  import poa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_NUM_W-1:0]  num;
  logic [DIV_DEN_W-1:0]  den;
  logic [DIV_DEN_W:0]    rem;
  logic [DIV_NUM_W-1:0]  quo;
  logic [DIV_STEP_W-1:0] step;
  logic                  run;
  logic                  zero_total;
  logic                  done;
  logic [PCT_W-1:0]      usage;

  logic [DIV_NUM_W-1:0]  num_init;
  logic [DIV_DEN_W:0]    rem_shift;
  logic [DIV_DEN_W:0]    rem_sub;
  logic                  fits;
  logic [DIV_NUM_W-1:0]  quo_final;

  // Numerator 200*used + T, rounded division by 2*T
  always_comb begin
    num_init  = DIV_NUM_W'(PCT_SCALE) * DIV_NUM_W'(req.used) + DIV_NUM_W'(req.total);
    rem_shift = {rem[DIV_DEN_W-1:0], num[DIV_NUM_W-1]};
    rem_sub   = rem_shift - {1'b0, den};
    fits      = (rem_shift >= {1'b0, den});
    quo_final = {quo[DIV_NUM_W-2:0], fits};
  end

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 1'b1;
        if (step == DIV_STEP_W'(DIV_NUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num        <= num_init;
      den        <= {req.total, 1'b0};
      rem        <= '0;
      quo        <= '0;
      zero_total <= (req.total == '0);
    end else if (run) begin
      num <= {num[DIV_NUM_W-2:0], 1'b0};
      rem <= fits ? rem_sub : rem_shift;
      quo <= quo_final;
      if (step == DIV_STEP_W'(DIV_NUM_W - 1)) begin
        if (zero_total) begin
          usage <= '0;
        end else if (quo_final > DIV_NUM_W'(PCT_MAX)) begin
          usage <= PCT_W'(PCT_MAX);
        end else begin
          usage <= quo_final[PCT_W-1:0];
        end
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.usage = usage;

endmodule

[src/page_owner_allocator.sv]
// Channel   Signals                                         Direction
// request   start, busy, mode, process_id, page_count       in (busy out)
// result    result_valid, page_index, page_valid, status,   out, one cycle each
//           usage_percent, last
// config    cfg_valid, cfg_ready, cfg_data (frame_limit)    in (ready out)
//
// A request keeps busy high through one ring rotation to count, a decide state, the
// usage division (15 steps and a done), and a second rotation that moves pages and
// issues one result per moved page. Too few free pages goes to the reply after the
// decide state; an evict that finds nothing owned replies after the division; a zero
// count or process zero goes straight to the reply. Each result shows the cycle after it is issued.
// Synchronous reset empties every page and sets frame_limit to 64; the receiver
// cannot stall and at most one result leaves per cycle.
module page_owner_allocator
  import poa_pkg::*;
#(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  mode,
  input  logic [PID_W-1:0]      process_id,
  input  logic [COUNT_W-1:0]    page_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COUNT_W-1:0]    cfg_data,
  output logic                  result_valid,
  output logic [PAGE_IDX_W-1:0] page_index,
  output logic                  page_valid,
  output logic [STATUS_W-1:0]   status,
  output logic [PCT_W-1:0]      usage_percent,
  output logic                  last
);

  localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

  state_t state, state_next;

  logic [COUNT_W-1:0]    frame_limit;
  logic [COUNT_W-1:0]    eff_total;
  logic [COUNT_W-1:0]    used_count;
  logic [PCT_W-1:0]      usage_reg;

  logic                  req_mode;
  logic [OWNER_BITS-1:0] req_pid;
  logic [COUNT_W-1:0]    req_count;
  logic [COUNT_W-1:0]    tally;
  logic [COUNT_W-1:0]    remain;
  logic [STATUS_W-1:0]   fin_status;
  logic [IDX_W-1:0]      head_idx;

  logic [7:0]            pid_wide;
  logic [OWNER_BITS-1:0] pid_own;
  logic                  trivial;

  logic [OWNER_BITS-1:0] chain [NUM_PAGES];
  logic [OWNER_BITS-1:0] head;
  logic [OWNER_BITS-1:0] tail_in;
  logic                  shift;
  logic                  writeback;
  logic                  match;
  logic                  pass_end;

  logic [COUNT_W-1:0]    n_move;
  logic [COUNT_W-1:0]    used_next;
  logic                  alloc_short;

  logic                  emit;
  logic [PAGE_IDX_W-1:0] emit_index;
  logic                  emit_valid;
  logic [STATUS_W-1:0]   emit_status;
  logic                  emit_last;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Request decode
  always_comb begin
    pid_wide  = {4'b0, process_id};
    pid_own   = pid_wide[OWNER_BITS-1:0];
    trivial   = (page_count == '0) || (pid_own == '0);
    eff_total = (frame_limit < COUNT_W'(NUM_PAGES)) ? frame_limit : COUNT_W'(NUM_PAGES);
  end

  // Owner ring: cell 0 is the head, the tail takes the head back
  assign head = chain[0];

  for (genvar i = 0; i < NUM_PAGES; i++) begin : g_cell
    logic [OWNER_BITS-1:0] cell_in;
    if (i == NUM_PAGES - 1) begin : g_tail
      assign cell_in = tail_in;
    end else begin : g_mid
      assign cell_in = chain[i+1];
    end
    poa_cell #(
      .OWNER_BITS(OWNER_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .owner_in (cell_in),
      .owner_out(chain[i])
    );
  end

  // Head page selection for the current request
  always_comb begin
    if (req_mode == MODE_ALLOC) begin
      match = (head == '0) && (COUNT_W'(head_idx) < eff_total);
    end else begin
      match = (head == req_pid);
    end
    pass_end = (head_idx == IDX_W'(NUM_PAGES - 1));
  end

  // Decision after the counting pass
  always_comb begin
    alloc_short = (tally < req_count);
    n_move      = (tally < req_count) ? tally : req_count;
    if (req_mode == MODE_ALLOC) begin
      used_next = used_count + req_count;
    end else if (used_count >= n_move) begin
      used_next = used_count - n_move;
    end else begin
      used_next = '0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = trivial ? ST_REPLY : ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (pass_end) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if ((req_mode == MODE_ALLOC) && alloc_short) begin
          state_next = ST_REPLY;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          state_next = (remain == '0) ? ST_REPLY : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (pass_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_REPLY: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    shift       = 1'b0;
    writeback   = 1'b0;
    emit        = 1'b0;
    emit_index  = '0;
    emit_valid  = 1'b0;
    emit_status = STAT_OK;
    emit_last   = 1'b0;
    div_req     = '0;
    unique case (state)
      ST_COUNT: begin
        shift = 1'b1;
      end
      ST_DECIDE: begin
        if (!((req_mode == MODE_ALLOC) && alloc_short)) begin
          div_req.start = 1'b1;
          div_req.used  = used_next;
          div_req.total = eff_total;
        end
      end
      ST_EMIT: begin
        shift = 1'b1;
        if (match && (remain != '0)) begin
          writeback   = 1'b1;
          emit        = 1'b1;
          emit_index  = PAGE_IDX_W'(head_idx);
          emit_valid  = 1'b1;
          emit_last   = (remain == COUNT_W'(1));
          emit_status = emit_last ? fin_status : STAT_OK;
        end
      end
      ST_REPLY: begin
        emit        = 1'b1;
        emit_status = fin_status;
        emit_last   = 1'b1;
      end
      default: begin
      end
    endcase
    if (writeback) begin
      tail_in = (req_mode == MODE_ALLOC) ? req_pid : '0;
    end else begin
      tail_in = head;
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= COUNT_W'(TOTAL_RST);
    end else if (cfg_valid && cfg_ready) begin
      frame_limit <= cfg_data;
    end
  end

  // Occupancy and usage
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      usage_reg  <= '0;
    end else begin
      if (div_req.start) begin
        used_count <= used_next;
      end
      if ((state == ST_DIVIDE) && div_rsp.done) begin
        usage_reg <= div_rsp.usage;
      end
    end
  end

  // Request bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      head_idx <= '0;
    end else if (shift) begin
      head_idx <= pass_end ? '0 : head_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          req_mode   <= mode;
          req_pid    <= pid_own;
          req_count  <= page_count;
          tally      <= '0;
          fin_status <= (mode == MODE_EVICT) ? STAT_EVICT : STAT_OK;
        end
      end
      ST_COUNT: begin
        if (match) begin
          tally <= tally + 1'b1;
        end
      end
      ST_DECIDE: begin
        if (req_mode == MODE_ALLOC) begin
          remain     <= req_count;
          fin_status <= alloc_short ? STAT_NOFREE : STAT_OK;
        end else begin
          remain     <= n_move;
          fin_status <= alloc_short ? STAT_EVICT : STAT_OK;
        end
      end
      ST_EMIT: begin
        if (writeback) begin
          remain <= remain - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold each result on the ports for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      page_index    <= emit_index;
      page_valid    <= emit_valid;
      status        <= emit_status;
      usage_percent <= usage_reg;
      last          <= emit_last;
    end
  end

  poa_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
  import poa_pkg::*;
;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 2 * NUM_PAGES_DEF + 20;
  localparam int DIRECTED_N   = 19;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 48;
  localparam int MAX_REPORTS  = 40;

  // One result as seen on the result ports
  typedef struct packed {
    logic [PAGE_IDX_W-1:0] idx;
    logic                  valid;
    logic [STATUS_W-1:0]   stat;
    logic [PCT_W-1:0]      pct;
    logic                  fin;
  } page_result_t;

  // One directed request; the expected result is typed in where has_exp is set
  typedef struct packed {
    logic                mode;
    logic [PID_W-1:0]    pid;
    logic [COUNT_W-1:0]  cnt;
    logic                has_exp;
    logic [STATUS_W-1:0] stat;
    logic [PCT_W-1:0]    pct;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  mode;
  logic [PID_W-1:0]      process_id;
  logic [COUNT_W-1:0]    page_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [COUNT_W-1:0]    cfg_data;
  logic                  result_valid;
  logic [PAGE_IDX_W-1:0] page_index;
  logic                  page_valid;
  logic [STATUS_W-1:0]   status;
  logic [PCT_W-1:0]      usage_percent;
  logic                  last;

  // Predicted allocator state
  logic [OWNER_BITS_DEF-1:0] owner_map [NUM_PAGES_DEF];
  int                        used_pages;
  logic [PCT_W-1:0]          usage_pct;
  logic [COUNT_W-1:0]        total_cfg;

  page_result_t request_results [$];
  page_result_t expected_moves [$];
  page_result_t want;

  stim_row_t          directed_rows [DIRECTED_N];
  logic [COUNT_W-1:0] phase_totals [PHASES];

  int n_alloc;
  int n_evict;
  int n_results;
  int n_errors;
  int cycle_count;

  page_owner_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .process_id   (process_id),
    .page_count   (page_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .page_index   (page_index),
    .page_valid   (page_valid),
    .status       (status),
    .usage_percent(usage_percent),
    .last         (last)
  );

  // Free-running clock
  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int eff_total();
    return (total_cfg < NUM_PAGES_DEF) ? int'(total_cfg) : NUM_PAGES_DEF;
  endfunction

  // Rounded half-up percentage, saturated
  function automatic logic [PCT_W-1:0] usage_of(int used, int t);
    int u;
    u = 0;
    if (t != 0) begin
      u = (PCT_SCALE * used + t) / (2 * t);
      if (u > PCT_MAX) u = PCT_MAX;
    end
    return u[PCT_W-1:0];
  endfunction

  function automatic int free_frames();
    int n;
    n = 0;
    for (int i = 0; i < eff_total(); i++)
      if (owner_map[i] == 0) n++;
    return n;
  endfunction

  function automatic int owned_by(logic [PID_W-1:0] pid);
    int n;
    n = 0;
    for (int i = 0; i < NUM_PAGES_DEF; i++)
      if (owner_map[i] == pid[OWNER_BITS_DEF-1:0]) n++;
    return n;
  endfunction

  // Prefer a process that holds pages, so evicts do real work
  function automatic logic [PID_W-1:0] pick_owner();
    int idx;
    for (int k = 0; k < 8; k++) begin
      idx = $urandom_range(0, NUM_PAGES_DEF - 1);
      if (owner_map[idx] != 0) return PID_W'(owner_map[idx]);
    end
    return PID_W'($urandom_range(1, 15));
  endfunction

  function automatic page_result_t lone_result(logic [STATUS_W-1:0] st);
    page_result_t r;
    r.idx   = '0;
    r.valid = 1'b0;
    r.stat  = st;
    r.pct   = usage_pct;
    r.fin   = 1'b1;
    return r;
  endfunction

  // Advance the predicted state by one request and list its results
  task automatic apply_request(input logic m, input logic [PID_W-1:0] p,
                               input logic [COUNT_W-1:0] c);
    int t;
    int moved;
    logic [OWNER_BITS_DEF-1:0] owner;
    logic [STATUS_W-1:0] st;
    page_result_t r;
    request_results.delete();
    t = eff_total();
    moved = 0;
    st = STAT_OK;
    owner = p[OWNER_BITS_DEF-1:0];
    r = '0;
    r.valid = 1'b1;
    if (m == MODE_ALLOC) begin
      n_alloc++;
      if (c == 0 || owner == 0) begin
        request_results.push_back(lone_result(STAT_OK));
        return;
      end
      if (free_frames() < c) begin
        request_results.push_back(lone_result(STAT_NOFREE));
        return;
      end
      // first fit below the active size
      for (int i = 0; i < t && moved < c; i++) begin
        if (owner_map[i] == 0) begin
          owner_map[i] = owner;
          used_pages++;
          moved++;
          r.idx = PAGE_IDX_W'(i);
          request_results.push_back(r);
        end
      end
    end else begin
      n_evict++;
      if (c == 0 || owner == 0) begin
        request_results.push_back(lone_result(STAT_EVICT));
        return;
      end
      // evict scans the whole built map
      for (int i = 0; i < NUM_PAGES_DEF && moved < c; i++) begin
        if (owner_map[i] == owner) begin
          owner_map[i] = 0;
          if (used_pages > 0) used_pages--;
          moved++;
          r.idx = PAGE_IDX_W'(i);
          request_results.push_back(r);
        end
      end
      if (moved < c) st = STAT_EVICT;
    end
    usage_pct = usage_of(used_pages, t);
    if (moved == 0) begin
      request_results.push_back(lone_result(st));
      return;
    end
    // stamp usage on every result, status and last on the final one
    foreach (request_results[k]) request_results[k].pct = usage_pct;
    request_results[moved-1].stat = st;
    request_results[moved-1].fin  = 1'b1;
  endtask

  // Hand one item to the block and record what it should produce
  task automatic send_request(input logic m, input logic [PID_W-1:0] p,
                              input logic [COUNT_W-1:0] c, input bit no_gap,
                              input bit has_exp, input logic [STATUS_W-1:0] exp_stat,
                              input logic [PCT_W-1:0] exp_pct);
    int gap;
    page_result_t r;
    gap = no_gap ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    mode       <= m;
    process_id <= p;
    page_count <= c;
    do @(posedge clk); while (busy);
    apply_request(m, p, c);
    if (has_exp) begin
      r = '0;
      r.stat = exp_stat;
      r.pct  = exp_pct;
      r.fin  = 1'b1;
      expected_moves.push_back(r);
    end else begin
      foreach (request_results[k]) expected_moves.push_back(request_results[k]);
    end
  endtask

  // Hold off until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk);
  endtask

  task automatic write_total(input logic [COUNT_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    total_cfg = v;
  endtask

  // Mostly well-formed allocate/evict traffic, with some noise and overruns
  task automatic random_request(input bit no_gap);
    int r;
    int sel;
    int f;
    int o;
    int c;
    logic m;
    logic [PID_W-1:0] p;
    r = $urandom_range(0, 99);
    sel = $urandom_range(0, 9);
    if (r < 12) begin
      m = 1'($urandom_range(0, 1));
      p = PID_W'($urandom_range(0, 15));
      case (sel % 4)
        0: c = 0;
        1: c = $urandom_range(65, 127);
        2: c = $urandom_range(0, 127);
        default: begin
          p = '0;
          c = $urandom_range(1, 127);
        end
      endcase
    end else if (r < 56) begin
      m = MODE_ALLOC;
      p = PID_W'($urandom_range(1, 15));
      f = free_frames();
      if (sel == 0) c = (f + 1 > 127) ? 127 : f + 1;
      else if (sel == 1 && f > 0) c = $urandom_range(1, f);
      else c = $urandom_range(1, (f < 1) ? 1 : ((f < 6) ? f : 6));
    end else begin
      m = MODE_EVICT;
      p = pick_owner();
      o = owned_by(p);
      if (sel == 0 || o == 0) c = o + $urandom_range(1, 3);
      else c = $urandom_range(1, o);
    end
    send_request(m, p, COUNT_W'(c), no_gap, 1'b0, STAT_OK, '0);
  endtask

  // Check every result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      n_results++;
      if (expected_moves.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: unexpected result idx=%0d valid=%0b status=%0d usage=%0d last=%0b",
                   $time, page_index, page_valid, status, usage_percent, last);
      end else begin
        want = expected_moves.pop_front();
        if (page_index !== want.idx || page_valid !== want.valid ||
            status !== want.stat || usage_percent !== want.pct || last !== want.fin) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("%0t: mismatch expected idx=%0d valid=%0b status=%0d usage=%0d last=%0b",
                     $time, want.idx, want.valid, want.stat, want.pct, want.fin);
            $display("%0t:          got      idx=%0d valid=%0b status=%0d usage=%0d last=%0b",
                     $time, page_index, page_valid, status, usage_percent, last);
          end
        end
      end
    end
  end

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    mode        = MODE_ALLOC;
    process_id  = '0;
    page_count  = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    n_alloc     = 0;
    n_evict     = 0;
    n_results   = 0;
    n_errors    = 0;
    cycle_count = 0;
    used_pages  = 0;
    usage_pct   = '0;
    total_cfg   = COUNT_W'(TOTAL_RST);
    foreach (owner_map[i]) owner_map[i] = '0;

    // mode, pid, count, typed?, status, usage
    directed_rows = '{
      '{MODE_ALLOC, 4'd1,  7'd0,   1'b1, STAT_OK,     7'd0},    // allocate zero
      '{MODE_ALLOC, 4'd0,  7'd5,   1'b1, STAT_OK,     7'd0},    // allocate for process zero
      '{MODE_EVICT, 4'd2,  7'd0,   1'b1, STAT_EVICT,  7'd0},    // evict zero count
      '{MODE_EVICT, 4'd0,  7'd3,   1'b1, STAT_EVICT,  7'd0},    // evict for process zero
      '{MODE_EVICT, 4'd5,  7'd3,   1'b1, STAT_EVICT,  7'd0},    // evict, nothing owned
      '{MODE_ALLOC, 4'd1,  7'd65,  1'b1, STAT_NOFREE, 7'd0},    // one more than exists
      '{MODE_ALLOC, 4'd15, 7'd127, 1'b1, STAT_NOFREE, 7'd0},    // largest count
      '{MODE_ALLOC, 4'd15, 7'd64,  1'b0, STAT_OK,     7'd0},    // fill every page
      '{MODE_ALLOC, 4'd1,  7'd1,   1'b1, STAT_NOFREE, 7'd100},  // full map
      '{MODE_EVICT, 4'd15, 7'd64,  1'b0, STAT_OK,     7'd0},    // empty it again
      '{MODE_ALLOC, 4'd1,  7'd3,   1'b0, STAT_OK,     7'd0},
      '{MODE_ALLOC, 4'd2,  7'd2,   1'b0, STAT_OK,     7'd0},
      '{MODE_ALLOC, 4'd3,  7'd1,   1'b0, STAT_OK,     7'd0},
      '{MODE_EVICT, 4'd1,  7'd2,   1'b0, STAT_OK,     7'd0},    // leave holes
      '{MODE_ALLOC, 4'd4,  7'd3,   1'b0, STAT_OK,     7'd0},    // first fit into holes
      '{MODE_EVICT, 4'd2,  7'd5,   1'b0, STAT_OK,     7'd0},    // evict more than owned
      '{MODE_EVICT, 4'd10, 7'd1,   1'b0, STAT_OK,     7'd0},
      '{MODE_ALLOC, 4'd10, 7'd33,  1'b0, STAT_OK,     7'd0},
      '{MODE_EVICT, 4'd8,  7'd127, 1'b0, STAT_OK,     7'd0}
    };
    // size settings per random phase, extremes included
    phase_totals = '{7'd64, 7'd127, 7'd16, 7'd1, 7'd0, 7'd40, 7'd64, 7'd100, 7'd8, 7'd64};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset size
    foreach (directed_rows[k])
      send_request(directed_rows[k].mode, directed_rows[k].pid, directed_rows[k].cnt,
                   1'b0, directed_rows[k].has_exp, directed_rows[k].stat,
                   directed_rows[k].pct);

    // Random phases, each under its own size setting
    for (int ph = 0; ph < PHASES; ph++) begin
      write_total(phase_totals[ph]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 24) == 0) drain_results();
        random_request(ph % 3 == 1);
      end
    end

    // Drop start, drain, and let the block settle
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (expected_moves.size() != 0) n_errors++;

    $display("Run covered %0d allocate and %0d evict requests, %0d results checked,",
             n_alloc, n_evict, n_results);
    $display("under %0d page-count settings from 0 to 127, with and without gaps.",
             PHASES + 1);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
